FILE: rtl/core/pcc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the sine table for the preamble correlator
// no dependencies; imported by pcc_tap_unit and the top level
package pcc_pkg;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  localparam int THRESH_W = 23;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 23'd4194304;

  localparam int CORR_MAX_I = 8388607;
  localparam int CORR_MIN_I = -8388608;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic               start_flag;
    logic signed [15:0] freq_offset;
    logic [5:0]         coef_index;
    logic signed [15:0] coef_re;
    logic signed [15:0] coef_im;
  } req_t;

  typedef struct packed {
    logic signed [15:0] delayed_re;
    logic signed [15:0] delayed_im;
    logic signed [23:0] corr_re;
    logic signed [23:0] corr_im;
    logic               detected;
  } rsp_t;

  typedef struct packed {
    logic               flag;
    logic [15:0]        offset;
    logic signed [15:0] im;
    logic signed [15:0] re;
  } win_entry_t;

  typedef struct packed {
    logic       clear;
    logic       valid;
    logic [6:0] pidx;
  } tap_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_RUN,
    ST_DRAIN,
    ST_ROUND,
    ST_SQUARE,
    ST_CMP,
    ST_DONE
  } seq_state_t;

  // round(32767*sin(i*pi/64)), i = 0..32
  localparam logic signed [15:0] QUARTER_SINE [0:32] = '{
    16'sd0,     16'sd1608,  16'sd3212,  16'sd4808,  16'sd6393,  16'sd7962,
    16'sd9512,  16'sd11039, 16'sd12539, 16'sd14010, 16'sd15446, 16'sd16846,
    16'sd18204, 16'sd19519, 16'sd20787, 16'sd22005, 16'sd23170, 16'sd24279,
    16'sd25330, 16'sd26319, 16'sd27245, 16'sd28106, 16'sd28898, 16'sd29621,
    16'sd30273, 16'sd30852, 16'sd31356, 16'sd31785, 16'sd32137, 16'sd32412,
    16'sd32609, 16'sd32728, 16'sd32767
  };

  // sine of a 7-bit phase, 128 points per period
  function automatic logic signed [15:0] sine7(input logic [6:0] idx);
    logic [5:0]         ti;
    logic signed [15:0] v;
    ti = idx[5] ? (6'd32 - {1'b0, idx[4:0]}) : {1'b0, idx[4:0]};
    v  = QUARTER_SINE[ti];
    return idx[6] ? -v : v;
  endfunction

endpackage

FILE: rtl/core/pcc_tap_unit.sv
`timescale 1ns / 1ps
// shared rotate-and-multiply unit: one window tap per cycle into a pipeline
// depends on pcc_pkg (tap_ctl_t, sine7)
module pcc_tap_unit #(
  parameter int ACC_W = 56
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pcc_pkg::tap_ctl_t    ctl,
  input  logic signed [15:0]   x_re,
  input  logic signed [15:0]   x_im,
  input  logic signed [15:0]   c_re,
  input  logic signed [15:0]   c_im,
  output logic signed [ACC_W-1:0] acc_re,
  output logic signed [ACC_W-1:0] acc_im,
  output logic                 busy
);
  import pcc_pkg::*;

  logic signed [15:0] sn, cs;

  // stage 1: sample times rotator
  logic               v1;
  logic signed [31:0] m_rc, m_is, m_rs, m_ic;
  logic signed [15:0] cr1, ci1;
  // stage 2: rotated sample
  logic               v2;
  logic signed [32:0] rr, ri;
  logic signed [15:0] cr2, ci2;
  // stage 3: rotated sample times coefficient
  logic               v3;
  logic signed [48:0] q_rr, q_ii, q_ri, q_ir;

  assign sn = sine7(ctl.pidx);
  assign cs = sine7(ctl.pidx + 7'd32);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    m_rc <= x_re * cs;
    m_is <= x_im * sn;
    m_rs <= x_re * sn;
    m_ic <= x_im * cs;
    cr1  <= c_re;
    ci1  <= c_im;

    rr  <= 33'(m_rc) - 33'(m_is);
    ri  <= 33'(m_rs) + 33'(m_ic);
    cr2 <= cr1;
    ci2 <= ci1;

    q_rr <= rr * cr2;
    q_ii <= ri * ci2;
    q_ri <= rr * ci2;
    q_ir <= ri * cr2;

    if (ctl.clear) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (v3) begin
      acc_re <= acc_re + ACC_W'(q_rr) - ACC_W'(q_ii);
      acc_im <= acc_im + ACC_W'(q_ri) + ACC_W'(q_ir);
    end
  end

  assign busy = v1 | v2 | v3;

endmodule

FILE: rtl/core/preamble_correlator_with_cfo_rotation_unit.sv
`timescale 1ns / 1ps
// a coefficient load is written when it is accepted. a sample whose oldest window entry is
// unflagged passes the head and done states before its result is registered; a flagged one
// passes head, run, drain, round, square, compare and done, one window tap per cycle in run
// through the shared rotate-and-multiply unit. requests are taken only in the idle state:
// a sample finishes before another is taken, and rsp_stall can hold the done state. reset (synchronous) clears the
// sequencer, write pointer, fill count and threshold; coefficients are undefined
module preamble_correlator_with_cfo_rotation_unit #(
  parameter int SEQ_LEN = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  pcc_pkg::req_t req_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output pcc_pkg::rsp_t rsp_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import pcc_pkg::*;

  localparam int AW    = (SEQ_LEN > 1) ? $clog2(SEQ_LEN) : 1;
  localparam int FW    = $clog2(SEQ_LEN + 1);
  localparam int ACC_W = 50 + AW;
  localparam logic [AW-1:0] LAST = AW'(SEQ_LEN - 1);
  localparam logic [FW-1:0] FULL = FW'(SEQ_LEN);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(CORR_MAX_I);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(CORR_MIN_I);
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< 29;

  seq_state_t state, state_next;

  logic [THRESH_W-1:0] threshold;
  logic [AW-1:0] wp, wp_next, slot, k, rd_addr;
  logic [FW-1:0] fill;
  logic [15:0]   ph, head_off;
  logic signed [15:0] head_re, head_im;

  win_entry_t win_mem [SEQ_LEN];
  logic signed [15:0] coef_re_mem [SEQ_LEN];
  logic signed [15:0] coef_im_mem [SEQ_LEN];
  win_entry_t win_rdata, win_entry;
  logic signed [15:0] coef_re_rd, coef_im_rd;

  logic       rd_vld, rd_ok;
  logic [6:0] rd_pidx;

  tap_ctl_t tap_ctl;
  logic signed [ACC_W-1:0] acc_re, acc_im, rnd_re, rnd_im;
  logic tap_busy;

  logic signed [23:0] c_re, c_im;
  logic [46:0] sq_re, sq_im;
  logic [45:0] th_sq;
  logic det_r;

  logic accept, is_sample, is_load, load_ok, head_ok, out_free, cfg_wr;

  assign accept    = req_valid && !req_stall;
  assign is_sample = accept && (req_data.operation == OP_SAMPLE);
  assign is_load   = accept && (req_data.operation == OP_LOAD);
  assign load_ok   = 32'(req_data.coef_index) < SEQ_LEN;
  assign wp_next   = (wp == LAST) ? '0 : wp + 1'b1;
  assign head_ok   = FW'(wp) < fill;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD);
  assign prdata = (paddr[2] == REG_THRESHOLD) ? {{(32 - THRESH_W){1'b0}}, threshold} : '0;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = slot;
    case (state)
      ST_IDLE: begin
        rd_addr = wp_next;
        if (is_sample) state_next = ST_HEAD;
      end
      ST_HEAD: begin
        state_next = (head_ok && win_rdata.flag) ? ST_RUN : ST_DONE;
      end
      ST_RUN: begin
        if (k == LAST) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!rd_vld && !tap_busy) state_next = ST_ROUND;
      end
      ST_ROUND:  state_next = ST_SQUARE;
      ST_SQUARE: state_next = ST_CMP;
      ST_CMP:    state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // window and coefficient memories
  always_comb begin
    win_entry.flag   = req_data.start_flag;
    win_entry.offset = req_data.freq_offset;
    win_entry.im     = req_data.sample_im;
    win_entry.re     = req_data.sample_re;
  end

  always_ff @(posedge clk) begin
    if (is_sample) win_mem[wp] <= win_entry;
    win_rdata <= win_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (is_load && load_ok) begin
      coef_re_mem[AW'(req_data.coef_index)] <= req_data.coef_re;
      coef_im_mem[AW'(req_data.coef_index)] <= req_data.coef_im;
    end
    coef_re_rd <= coef_re_mem[k];
    coef_im_rd <= coef_im_mem[k];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      wp        <= '0;
      fill      <= '0;
      rd_vld    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_wr) threshold <= pwdata[THRESH_W-1:0];
      if (is_sample) begin
        wp <= wp_next;
        if (fill != FULL) fill <= fill + 1'b1;
      end
      rd_vld <= (state == ST_RUN);
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // rounding to q.15 and saturation
  assign rnd_re = (acc_re + RND) >>> 30;
  assign rnd_im = (acc_im + RND) >>> 30;

  // datapath registers
  always_ff @(posedge clk) begin
    rd_ok   <= FW'(slot) < fill;
    rd_pidx <= ph[15:9];
    case (state)
      ST_HEAD: begin
        head_re  <= head_ok ? win_rdata.re : '0;
        head_im  <= head_ok ? win_rdata.im : '0;
        head_off <= win_rdata.offset;
        k        <= '0;
        slot     <= wp;
        ph       <= '0;
        c_re     <= '0;
        c_im     <= '0;
        det_r    <= 1'b0;
      end
      ST_RUN: begin
        k    <= k + 1'b1;
        slot <= (slot == LAST) ? '0 : slot + 1'b1;
        ph   <= ph + head_off;
      end
      ST_ROUND: begin
        c_re <= (rnd_re > SAT_HI) ? 24'(SAT_HI) :
                (rnd_re < SAT_LO) ? 24'(SAT_LO) : 24'(rnd_re);
        c_im <= (rnd_im > SAT_HI) ? 24'(SAT_HI) :
                (rnd_im < SAT_LO) ? 24'(SAT_LO) : 24'(rnd_im);
      end
      ST_SQUARE: begin
        sq_re <= 47'(c_re * c_re);
        sq_im <= 47'(c_im * c_im);
        th_sq <= 46'(threshold * threshold);
      end
      ST_CMP: begin
        det_r <= ({1'b0, sq_re} + {1'b0, sq_im}) > {2'b00, th_sq};
      end
      ST_DONE: begin
        if (out_free) begin
          rsp_data.delayed_re <= head_re;
          rsp_data.delayed_im <= head_im;
          rsp_data.corr_re    <= c_re;
          rsp_data.corr_im    <= c_im;
          rsp_data.detected   <= det_r;
        end
      end
      default: begin
      end
    endcase
  end

  // entries past the fill count read as zero
  always_comb begin
    tap_ctl.clear = (state == ST_HEAD);
    tap_ctl.valid = rd_vld;
    tap_ctl.pidx  = rd_pidx;
  end

  pcc_tap_unit #(
    .ACC_W(ACC_W)
  ) u_tap (
    .clk    (clk),
    .rst    (rst),
    .ctl    (tap_ctl),
    .x_re   (rd_ok ? win_rdata.re : 16'sd0),
    .x_im   (rd_ok ? win_rdata.im : 16'sd0),
    .c_re   (coef_re_rd),
    .c_im   (coef_im_rd),
    .acc_re (acc_re),
    .acc_im (acc_im),
    .busy   (tap_busy)
  );

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL)
    else $error("fill count beyond window length");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_DONE)
    else $error("response raised outside done state");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && k == LAST) |=> state == ST_DRAIN)
    else $error("tap sweep did not end after last tap");

  a_unflagged_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HEAD && !(head_ok && win_rdata.flag)) |=>
      (c_re == 24'sd0 && c_im == 24'sd0 && !det_r && state == ST_DONE))
    else $error("unflagged window produced nonzero correlation");
`endif

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// testbench for preamble_correlator_with_cfo_rotation_unit: directed and random requests
// checked against a bit-exact correlation predictor, threshold set over apb between phases
// depends on pcc_pkg and the rtl top level
module tb;
  import pcc_pkg::*;

  localparam int SEQ_LEN     = 64;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [22:0] THRESH_AT_RESET = 23'd4194304;

  // round(32767*sin(i*pi/64)), i = 0..32
  localparam int QSIN [33] = '{
    0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
    12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
    23170, 24279, 25330, 26319, 27245, 28106, 28898, 29621,
    30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
    32767
  };

  logic        clk;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  req_t        req_data  = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  preamble_correlator_with_cfo_rotation_unit #(.SEQ_LEN(SEQ_LEN)) dut (.*);

  // predicted block state
  logic signed [15:0] win_re   [SEQ_LEN];
  logic signed [15:0] win_im   [SEQ_LEN];
  logic               win_flag [SEQ_LEN];
  logic [15:0]        win_ofs  [SEQ_LEN];
  logic signed [15:0] coef_re  [SEQ_LEN];
  logic signed [15:0] coef_im  [SEQ_LEN];
  int                 wr_pos;
  logic [22:0]        threshold;

  rsp_t due_results [$];
  int   mismatches   = 0;
  int   cycle_count  = 0;
  bit   idle_on      = 1'b1;
  bit   hold_off_req = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic longint tab_sine(input logic [6:0] idx);
    longint v;
    v = idx[5] ? longint'(QSIN[32 - idx[4:0]]) : longint'(QSIN[idx[4:0]]);
    return idx[6] ? -v : v;
  endfunction

  // q.45 sum to q.15, floor after adding half, then clip to 24 bits
  function automatic longint round_sat(input longint v);
    longint q;
    q = (v + 64'sd536870912) >>> 30;
    if (q > 8388607) begin
      q = 8388607;
    end else if (q < -8388608) begin
      q = -8388608;
    end
    return q;
  endfunction

  // result for the window as it stands after the newest sample went in
  function automatic rsp_t correlate_oldest();
    rsp_t        o;
    int          k, slot;
    logic [15:0] fo, phase;
    logic [6:0]  sidx, cidx;
    longint      xr, xi, sn, cs, rr, ri, acc_re, acc_im, c_re, c_im, mag, lim;
    o = '0;
    o.delayed_re = win_re[wr_pos];
    o.delayed_im = win_im[wr_pos];
    if (win_flag[wr_pos]) begin
      fo     = win_ofs[wr_pos];
      acc_re = 0;
      acc_im = 0;
      for (k = 0; k < SEQ_LEN; k++) begin
        slot  = (wr_pos + k) % SEQ_LEN;
        phase = fo * 16'(k);
        sidx  = phase[15:9];
        cidx  = sidx + 7'd32;
        sn    = tab_sine(sidx);
        cs    = tab_sine(cidx);
        xr    = longint'(win_re[slot]);
        xi    = longint'(win_im[slot]);
        rr    = xr * cs - xi * sn;
        ri    = xr * sn + xi * cs;
        acc_re += rr * coef_re[k] - ri * coef_im[k];
        acc_im += rr * coef_im[k] + ri * coef_re[k];
      end
      c_re = round_sat(acc_re);
      c_im = round_sat(acc_im);
      mag  = c_re * c_re + c_im * c_im;
      lim  = longint'(threshold) * longint'(threshold);
      o.corr_re  = c_re[23:0];
      o.corr_im  = c_im[23:0];
      o.detected = (mag > lim);
    end
    return o;
  endfunction

  // track every accepted request
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      if (req_data.operation == OP_LOAD) begin
        if (req_data.coef_index < SEQ_LEN) begin
          coef_re[req_data.coef_index] = req_data.coef_re;
          coef_im[req_data.coef_index] = req_data.coef_im;
        end
      end else begin
        win_re[wr_pos]   = req_data.sample_re;
        win_im[wr_pos]   = req_data.sample_im;
        win_flag[wr_pos] = req_data.start_flag;
        win_ofs[wr_pos]  = req_data.freq_offset;
        wr_pos = (wr_pos + 1) % SEQ_LEN;
        due_results.push_back(correlate_oldest());
      end
    end
  end

  task automatic compare_field(input string name, input logic [23:0] want_v,
                               input logic [23:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t %s mismatch: expected %h, actual %h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none, actual %h", $time, rsp_data);
      end else begin
        want = due_results.pop_front();
        compare_field("delayed_re", 24'(want.delayed_re), 24'(rsp_data.delayed_re));
        compare_field("delayed_im", 24'(want.delayed_im), 24'(rsp_data.delayed_im));
        compare_field("corr_re", want.corr_re, rsp_data.corr_re);
        compare_field("corr_im", want.corr_im, rsp_data.corr_im);
        compare_field("detected", 24'(want.detected), 24'(rsp_data.detected));
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : rsp_side
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 12);
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  // offer one request and return at the edge that takes it; valid stays up
  task automatic send_item(input req_t r);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data  <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [15:0] re, im, input logic flag,
                             input logic signed [15:0] ofs);
    req_t r;
    r.operation   = OP_SAMPLE;
    r.sample_re   = re;
    r.sample_im   = im;
    r.start_flag  = flag;
    r.freq_offset = ofs;
    r.coef_index  = 6'($urandom);
    r.coef_re     = 16'($urandom);
    r.coef_im     = 16'($urandom);
    send_item(r);
  endtask

  task automatic send_load(input logic [5:0] idx, input logic signed [15:0] re, im);
    req_t r;
    r.operation   = OP_LOAD;
    r.sample_re   = 16'($urandom);
    r.sample_im   = 16'($urandom);
    r.start_flag  = 1'($urandom);
    r.freq_offset = 16'($urandom);
    r.coef_index  = idx;
    r.coef_re     = re;
    r.coef_im     = im;
    send_item(r);
  endtask

  // drop valid and let the block go quiet before touching the register
  task automatic settle();
    req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SEQ_LEN + 16) @(posedge clk);
  endtask

  // optional write, then a read-back of the threshold
  task automatic program_threshold(input bit do_write, input logic [22:0] value);
    paddr  <= {REG_THRESHOLD, 2'b00};
    pwdata <= {9'd0, value};
    psel   <= 1'b1;
    if (do_write) begin
      pwrite <= 1'b1;
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      threshold = value;
      penable <= 1'b0;
    end
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {9'd0, threshold}) begin
      mismatches++;
      $display("%0t threshold read mismatch: expected %h, actual %h", $time,
               {9'd0, threshold}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mix of preamble windows (some matched to the coefficients), noise and loads
  task automatic run_traffic(input int n_items);
    int                 sent, kind, len, k;
    bit                 coherent;
    logic               flag;
    logic signed [15:0] ofs;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        coherent = (kind <= 2);
        // a cut-short window leaves its flag to meet unrelated samples
        len = (kind == 5) ? $urandom_range(8, 48) : SEQ_LEN;
        for (k = 0; k < len; k++) begin
          flag = (k == 0) || ($urandom_range(0, 15) == 0);
          if (coherent && $urandom_range(0, 3) == 0) begin
            ofs = '0;
          end else if (coherent) begin
            ofs = 16'($urandom_range(0, 64) - 32);
          end else begin
            ofs = 16'($urandom);
          end
          if (coherent) begin
            // conjugate of the stored coefficient, halved so it cannot overflow
            send_sample(coef_re[k] >>> 1, -(coef_im[k] >>> 1), flag, ofs);
          end else begin
            send_sample(16'($urandom), 16'($urandom), flag, ofs);
          end
        end
      end else if (kind <= 7) begin
        len = 16;
        for (k = 0; k < len; k++) begin
          send_sample(16'($urandom), 16'($urandom), $urandom_range(0, 3) == 0,
                      16'($urandom));
        end
      end else begin
        len = 1;
        send_load(6'($urandom_range(0, SEQ_LEN - 1)), 16'($urandom), 16'($urandom));
      end
      sent += len;
    end
  endtask

  task automatic test_reset_defaults();
    program_threshold(1'b0, '0);
  endtask

  // every coefficient is written before any flagged window can reach it
  task automatic test_coef_loads();
    int i;
    send_load(0, -32768, -32768);
    send_load(1, 32767, 32767);
    send_load(2, -32768, 32767);
    send_load(3, 32767, -32768);
    send_load(4, 0, 0);
    for (i = 5; i < SEQ_LEN; i++) begin
      send_load(6'(i), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed_samples();
    send_sample(-32768, -32768, 1'b1, -32768);
    send_sample(32767, 32767, 1'b1, 32767);
    send_sample(-32768, 32767, 1'b0, 0);
    send_sample(32767, -32768, 1'b1, 0);
    send_sample(0, 0, 1'b1, 1);
    send_sample(32767, 0, 1'b1, 512);
    send_sample(0, -32768, 1'b0, -1);
    send_load(6'(SEQ_LEN - 1), -32768, 32767);
    send_sample(1, -1, 1'b1, 16384);
    send_sample(-1, 1, 1'b1, -16384);
    // half a table step: phase index truncation
    send_sample(12345, -12345, 1'b1, 256);
    send_sample(-32768, 0, 1'b1, 32768 - 512);
  endtask

  task automatic test_default_threshold();
    run_traffic(120);
    settle();
  endtask

  task automatic test_threshold_sweep();
    logic [22:0] levels [6];
    int          i;
    levels[0] = '0;
    levels[1] = 23'd8388607;
    levels[2] = 23'd1;
    for (i = 3; i < 6; i++) begin
      levels[i] = 23'($urandom_range(100000, 1500000));
    end
    for (i = 0; i < 6; i++) begin
      program_threshold(1'b1, levels[i]);
      run_traffic(220);
      settle();
    end
  endtask

  // receiver holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    program_threshold(1'b1, 23'($urandom_range(100000, 1500000)));
    hold_off_req = 1'b1;
    run_traffic(150);
    settle();
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    run_traffic(250);
  endtask

  initial begin : main
    int i;
    for (i = 0; i < SEQ_LEN; i++) begin
      win_re[i]   = '0;
      win_im[i]   = '0;
      win_flag[i] = 1'b0;
      win_ofs[i]  = '0;
      coef_re[i]  = '0;
      coef_im[i]  = '0;
    end
    wr_pos    = 0;
    threshold = THRESH_AT_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_coef_loads();
    test_directed_samples();
    test_default_threshold();
    test_threshold_sweep();
    test_backpressure();
    test_steady_stream();
    settle();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/pcc_pkg.sv
rtl/core/pcc_tap_unit.sv
rtl/core/preamble_correlator_with_cfo_rotation_unit.sv
tb/tb.sv
